// ----- hw/rtl/mgsa_pkg.sv -----
package mgsa_pkg;

    // Fixed field widths of one request and one response word.
    localparam int unsigned REQ_W      = 2;
    localparam int unsigned CHAN_W     = 6;
    localparam int unsigned POS_W      = 12;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned CFG_W      = 7;
    // Plane area is the product of two configuration fields.
    localparam int unsigned AREA_W     = 2 * CFG_W;
    // Flat index channel * area + position.
    localparam int unsigned IDX_W      = CHAN_W + AREA_W + 1;

    // APB port geometry: three registers on a 32-bit data bus at byte addresses 0, 4 and 8.
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // Defaults for the top-level parameters.
    localparam int unsigned DEF_BUFFER_DEPTH = 1024;
    localparam int unsigned DEF_DELTA_WIDTH  = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_IDX_COUNT  = 2'd2;

    // Reset values of the registers.
    localparam logic [CFG_W-1:0] CFG_RST_WIDTH  = 7'd4;
    localparam logic [CFG_W-1:0] CFG_RST_HEIGHT = 7'd4;
    localparam logic [CFG_W-1:0] CFG_RST_COUNT  = 7'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ACCUM = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_type;

    typedef struct packed {
        logic [CFG_W-1:0] plane_width;
        logic [CFG_W-1:0] plane_height;
        logic [CFG_W-1:0] channel_count;
    } t_cfg;

    // Controller to datapath.
    typedef struct packed {
        logic capture;   // load the request word
        logic calc;      // form flat index and range checks
        logic rd;        // read the store entry
        logic upd;       // write back and load the response register
        logic clr_wr;    // write zero at the clear pointer
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clr_last;  // clear pointer is at the last entry
        logic out_free;  // response register can take a word this cycle
    } t_sts;

endpackage

// ----- hw/rtl/mgsa_req_if.sv -----
interface mgsa_req_if
    import mgsa_pkg::*;
#(
    parameter int unsigned DELTA_WIDTH = DEF_DELTA_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic [REQ_W-1:0]              req_type;
    logic [CHAN_W-1:0]             channel;
    logic [POS_W-1:0]              position;
    logic signed [DELTA_WIDTH-1:0] delta;

    modport source (output valid, output req_type, output channel, output position,
                    output delta, input ready);
    modport sink   (input valid, input req_type, input channel, input position,
                    input delta, output ready);
endinterface

// ----- hw/rtl/mgsa_rsp_if.sv -----
interface mgsa_rsp_if
    import mgsa_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      error;

    modport source (output valid, output value, output error, input ready);
    modport sink   (input valid, input value, input error, output ready);
endinterface

// ----- hw/rtl/maxpool_gradient_scatter_accumulate_top.sv -----
// An accumulate or read word gives its response word once its calc, read and update steps are done.
// No new word is taken until the previous accumulate or read has finished its update step (single-port
// read-modify-write of the gradient store); a clear word zeroes the store one entry per cycle.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the store, during which no request
// word is taken (configuration writes are taken as ever).
module maxpool_gradient_scatter_accumulate_top
    import mgsa_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int unsigned DELTA_WIDTH  = DEF_DELTA_WIDTH
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mgsa_req_if.sink              i_req,
    mgsa_rsp_if.source            o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // The block keeps the gradient store of the layer in front of a max-pooling
    // layer. Since position = row * width + col with col below width, the flat
    // index (channel * height + row) * width + col equals channel * area +
    // position, so no division is needed: one multiply per request forms it.
    //
    // Flow of an accumulate or read word:
    //   accept - the request word is captured;
    //   calc   - flat index and the channel and position range checks;
    //   read   - store entry read into a register, index checked against depth;
    //   update - saturating sum written back (accumulate only) and the
    //            response word loaded into the output register.
    // The output register decouples the sides: the next request word is taken
    // while an earlier response word still waits; only the update step waits
    // when the output register is full and not being drained.

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    mgsa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The controller sequences clearing passes and the steps of each request.
    mgsa_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_req.valid),
        .i_in_req_type (t_req_type'(i_req.req_type)),
        .i_sts         (w_sts),
        .o_in_ready    (w_in_ready),
        .o_cmd         (w_cmd)
    );

    // The datapath holds the store, the index arithmetic and the response register.
    mgsa_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .DELTA_WIDTH  (DELTA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (w_cfg),
        .i_req_type  (t_req_type'(i_req.req_type)),
        .i_channel   (i_req.channel),
        .i_position  (i_req.position),
        .i_delta     (i_req.delta),
        .i_out_ready (o_rsp.ready),
        .o_sts       (w_sts),
        .o_out_valid (o_rsp.valid),
        .o_value     (o_rsp.value),
        .o_error     (o_rsp.error)
    );

    assign i_req.ready = w_in_ready;

endmodule

// ----- hw/rtl/mgsa_cfg.sv -----
module mgsa_cfg
    import mgsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [CFG_W-1:0] r_count;
    logic             w_wr;
    logic [1:0]       w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_RST_WIDTH;
            r_height <= CFG_RST_HEIGHT;
            r_count  <= CFG_RST_COUNT;
        end else if (w_wr) begin
            if (w_idx == CFG_IDX_WIDTH) begin
                r_width <= pwdata[CFG_W-1:0];
            end
            if (w_idx == CFG_IDX_HEIGHT) begin
                r_height <= pwdata[CFG_W-1:0];
            end
            if (w_idx == CFG_IDX_COUNT) begin
                r_count <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            CFG_IDX_WIDTH:  prdata = APB_DATA_W'(r_width);
            CFG_IDX_HEIGHT: prdata = APB_DATA_W'(r_height);
            CFG_IDX_COUNT:  prdata = APB_DATA_W'(r_count);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.plane_width   = r_width;
    assign o_cfg.plane_height  = r_height;
    assign o_cfg.channel_count = r_count;

endmodule

// ----- hw/rtl/mgsa_ctrl.sv -----
module mgsa_ctrl
    import mgsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_req_type i_in_req_type,
    input  t_sts      i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_READ,
        S_UPD
    } t_state;

    t_state r_state;
    logic   r_ready;
    t_cmd   r_cmd;
    t_state n_state;
    t_cmd   n_cmd;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_req_type)
                        REQ_CLEAR: n_state = S_CLEAR;
                        REQ_ACCUM: n_state = S_CALC;
                        REQ_READ:  n_state = S_CALC;
                        REQ_NONE:  n_state = S_IDLE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CALC: n_state = S_READ;
            S_READ: n_state = S_UPD;
            S_UPD: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Commands for the cycle after the transition, registered.
    always_comb begin
        n_cmd         = '0;
        n_cmd.clr_wr  = (n_state == S_CLEAR);
        n_cmd.calc    = (n_state == S_CALC);
        n_cmd.rd      = (n_state == S_READ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_ready        <= 1'b0;
            r_cmd          <= '{clr_wr: 1'b1, default: 1'b0};
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
            r_cmd   <= n_cmd;
        end
    end

    // Capture and write-back depend on the handshake seen in this cycle.
    always_comb begin
        o_cmd         = r_cmd;
        o_cmd.capture = r_ready && i_in_valid;
        o_cmd.upd     = (r_state == S_UPD) && i_sts.out_free;
    end

    assign o_in_ready = r_ready;

endmodule

// ----- hw/rtl/mgsa_dp.sv -----
module mgsa_dp
    import mgsa_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int unsigned DELTA_WIDTH  = DEF_DELTA_WIDTH
)(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  t_cfg                          i_cfg,
    input  t_req_type                     i_req_type,
    input  logic [CHAN_W-1:0]             i_channel,
    input  logic [POS_W-1:0]              i_position,
    input  logic signed [DELTA_WIDTH-1:0] i_delta,
    input  logic                          i_out_ready,
    output t_sts                          o_sts,
    output logic                          o_out_valid,
    output logic signed [VALUE_W-1:0]     o_value,
    output logic                          o_error
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam int unsigned EW = DELTA_WIDTH + VALUE_W;

    logic signed [DELTA_WIDTH-1:0] r_mem [BUFFER_DEPTH];

    logic [AREA_W-1:0]             r_area;
    t_req_type                     r_req;
    logic [CHAN_W-1:0]             r_ch;
    logic [POS_W-1:0]              r_pos;
    logic signed [DELTA_WIDTH-1:0] r_delta;
    logic [IDX_W-1:0]              r_idx;
    logic                          r_bad;
    logic                          r_bad_rd;
    logic signed [DELTA_WIDTH-1:0] r_rdata;
    logic [AW-1:0]                 r_clr_ptr;
    logic                          r_out_valid;
    logic signed [VALUE_W-1:0]     r_value;
    logic                          r_error;

    logic signed [DELTA_WIDTH:0]   w_sum;
    logic signed [DELTA_WIDTH-1:0] w_sat;
    logic signed [DELTA_WIDTH-1:0] w_res;
    logic [EW-1:0]                 w_ext;
    logic                          w_wr_acc;

    // Plane area follows the configuration; it is stable before any request.
    always_ff @(posedge i_clk) begin
        r_area <= AREA_W'(i_cfg.plane_width) * AREA_W'(i_cfg.plane_height);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= i_req_type;
            r_ch    <= i_channel;
            r_pos   <= i_position;
            r_delta <= i_delta;
        end
        if (i_cmd.calc) begin
            r_idx <= IDX_W'(r_ch) * IDX_W'(r_area) + IDX_W'(r_pos);
            r_bad <= (CFG_W'(r_ch) >= i_cfg.channel_count)
                  || (AREA_W'(r_pos) >= r_area);
        end
        if (i_cmd.rd) begin
            r_bad_rd <= r_bad || (r_idx >= IDX_W'(BUFFER_DEPTH));
            r_rdata  <= r_mem[r_idx[AW-1:0]];
        end
    end

    // Saturating add in one extra bit.
    assign w_sum = {r_rdata[DELTA_WIDTH-1], r_rdata} + {r_delta[DELTA_WIDTH-1], r_delta};
    always_comb begin
        if (w_sum[DELTA_WIDTH] != w_sum[DELTA_WIDTH-1]) begin
            w_sat = w_sum[DELTA_WIDTH] ? {1'b1, {(DELTA_WIDTH-1){1'b0}}}
                                       : {1'b0, {(DELTA_WIDTH-1){1'b1}}};
        end else begin
            w_sat = w_sum[DELTA_WIDTH-1:0];
        end
    end

    assign w_wr_acc = i_cmd.upd && !r_bad_rd && (r_req == REQ_ACCUM);

    always_comb begin
        if (r_bad_rd) begin
            w_res = '0;
        end else if (r_req == REQ_ACCUM) begin
            w_res = w_sat;
        end else begin
            w_res = r_rdata;
        end
    end

    // Entry width to response width: sign-extend or truncate.
    assign w_ext = {{VALUE_W{w_res[DELTA_WIDTH-1]}}, w_res};

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[r_clr_ptr] <= '0;
        end else if (w_wr_acc) begin
            r_mem[r_idx[AW-1:0]] <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ptr <= '0;
        end else if (i_cmd.clr_wr) begin
            if (r_clr_ptr == AW'(BUFFER_DEPTH - 1)) begin
                r_clr_ptr <= '0;
            end else begin
                r_clr_ptr <= r_clr_ptr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.upd) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_value <= w_ext[VALUE_W-1:0];
            r_error <= r_bad_rd;
        end
    end

    assign o_sts.clr_last = (r_clr_ptr == AW'(BUFFER_DEPTH - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_value        = r_value;
    assign o_error        = r_error;

endmodule

// ----- tb/sv/mgsa_gradient_checker.sv -----
module mgsa_gradient_checker
    import mgsa_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = DEF_BUFFER_DEPTH
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mgsa_req_if                   i_req_mon,
    mgsa_rsp_if                   i_rsp_mon,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output int unsigned           o_fail_count,
    output int unsigned           o_pending
);

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               error;
    } t_grad_reply;

    logic signed [VALUE_W-1:0] grad_model [BUFFER_DEPTH];
    logic [CFG_W-1:0]          model_width;
    logic [CFG_W-1:0]          model_height;
    logic [CFG_W-1:0]          model_count;
    t_grad_reply               awaited_replies [$];
    int unsigned               mismatches = 0;

    assign o_fail_count = mismatches;

    // Applies one accepted request word to the shadow store and queues the
    // response word it must produce, if any.
    task automatic scatter_accumulate(
        input logic [REQ_W-1:0]          kind,
        input logic [CHAN_W-1:0]         chan,
        input logic [POS_W-1:0]          pos,
        input logic signed [VALUE_W-1:0] grad
    );
        int unsigned             area;
        int unsigned             row;
        int unsigned             col;
        int unsigned             idx;
        bit                      bad;
        logic signed [VALUE_W:0] wide_sum;
        t_grad_reply             reply;

        case (kind)
            REQ_CLEAR: begin
                foreach (grad_model[k]) grad_model[k] = '0;
            end
            REQ_ACCUM, REQ_READ: begin
                area = model_width * model_height;
                bad  = (chan >= model_count) || (pos >= area) || (model_width == 0);
                idx  = 0;
                if (!bad) begin
                    row = pos / model_width;
                    col = pos % model_width;
                    idx = (chan * model_height + row) * model_width + col;
                    if (idx >= BUFFER_DEPTH) bad = 1'b1;
                end
                reply.value = '0;
                reply.error = bad;
                if (!bad) begin
                    if (kind == REQ_ACCUM) begin
                        wide_sum = grad_model[idx] + grad;
                        // The two top bits differ only when the sum left the
                        // Q16.16 range; the sign of the wide sum picks the rail.
                        if (wide_sum[VALUE_W] != wide_sum[VALUE_W-1]) begin
                            grad_model[idx] = wide_sum[VALUE_W] ?
                                {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
                        end else begin
                            grad_model[idx] = wide_sum[VALUE_W-1:0];
                        end
                    end
                    reply.value = grad_model[idx];
                end
                awaited_replies.push_back(reply);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_grad_reply want;

        if (!i_rst_n) begin
            foreach (grad_model[k]) grad_model[k] = '0;
            model_width  = CFG_RST_WIDTH;
            model_height = CFG_RST_HEIGHT;
            model_count  = CFG_RST_COUNT;
            awaited_replies.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_ADDR_W-1:2])
                    CFG_IDX_WIDTH:  model_width  = i_pwdata[CFG_W-1:0];
                    CFG_IDX_HEIGHT: model_height = i_pwdata[CFG_W-1:0];
                    CFG_IDX_COUNT:  model_count  = i_pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
            // Responses are checked before new requests are applied, since a
            // response word always belongs to an older request word.
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (awaited_replies.size() == 0) begin
                    $error("response word with no request outstanding: value %0d error %0d",
                           $signed(i_rsp_mon.value), i_rsp_mon.error);
                    mismatches++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_rsp_mon.value !== want.value) begin
                        $error("value mismatch: expected %0d, actual %0d",
                               $signed(want.value), $signed(i_rsp_mon.value));
                        mismatches++;
                    end
                    if (i_rsp_mon.error !== want.error) begin
                        $error("error mismatch: expected %0d, actual %0d",
                               want.error, i_rsp_mon.error);
                        mismatches++;
                    end
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                scatter_accumulate(i_req_mon.req_type, i_req_mon.channel,
                                   i_req_mon.position, i_req_mon.delta);
            end
        end
        o_pending <= awaited_replies.size();
    end

endmodule

// ----- tb/sv/tb_maxpool_gradient_scatter_accumulate_top.sv -----
module tb_maxpool_gradient_scatter_accumulate_top;
    import mgsa_pkg::*;

    localparam int unsigned RESET_CYCLES    = 12;
    // A clear word keeps the block busy for one pass over the store, so a
    // register write waits that long after the last response word.
    localparam int unsigned SETTLE_CYCLES   = DEF_BUFFER_DEPTH + 16;
    // Margin at the end in which any stray response word can still show.
    localparam int unsigned DRAIN_CYCLES    = 16;
    localparam int unsigned HOLD_CYCLES     = 300;
    // The longest correct quiet stretch is about two clear passes plus the
    // settle time, so this limit leaves several times that.
    localparam int unsigned WATCHDOG_LIMIT  = 10 * DEF_BUFFER_DEPTH;
    localparam int unsigned RANDOM_PHASES   = 12;
    localparam int unsigned WORDS_PER_PHASE = 102;
    localparam int unsigned GAP_PERCENT     = 20;
    localparam int unsigned NOISE_PERCENT   = 12;
    localparam int unsigned HOT_PERCENT     = 40;
    localparam int unsigned HOLD_PHASE      = 5;
    localparam int unsigned CALM_PHASE      = 7;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int unsigned           fail_count;
    int unsigned           pending_replies;

    // Geometry currently programmed, used only to aim the stimulus.
    int unsigned geo_w = CFG_RST_WIDTH;
    int unsigned geo_h = CFG_RST_HEIGHT;
    int unsigned geo_c = CFG_RST_COUNT;

    // When set, neither side inserts random idle cycles.
    bit          no_gaps      = 1'b0;
    // The stimulus asks for a long receiver hold-off by bumping holds_asked;
    // the receiver process serves each request once.
    int unsigned holds_asked  = 0;
    int unsigned holds_served = 0;
    int unsigned quiet_cycles = 0;

    mgsa_req_if #(.DELTA_WIDTH(DEF_DELTA_WIDTH)) req_bus ();
    mgsa_rsp_if rsp_bus ();

    maxpool_gradient_scatter_accumulate_top #(
        .BUFFER_DEPTH (DEF_BUFFER_DEPTH),
        .DELTA_WIDTH  (DEF_DELTA_WIDTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The checker watches both channels and the register port beside the
    // block; it keeps its own copy of the store and the geometry.
    mgsa_gradient_checker #(
        .BUFFER_DEPTH (DEF_BUFFER_DEPTH)
    ) gradient_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_mon    (req_bus),
        .i_rsp_mon    (rsp_bus),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_replies)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one request word and returns at the edge where it is taken.
    // Random idle cycles go in front of the word unless gaps are switched off.
    // The valid line is left high so that a following word goes out back to
    // back without a drop in between.
    task automatic send_word(
        input t_req_type                  kind,
        input logic [CHAN_W-1:0]          chan,
        input logic [POS_W-1:0]           pos,
        input logic [DEF_DELTA_WIDTH-1:0] grad
    );
        while (!no_gaps && $urandom_range(99) < GAP_PERCENT) begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.channel  <= chan;
        req_bus.position <= pos;
        req_bus.delta    <= grad;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
    endtask

    // Drops valid and waits until the checker holds no outstanding response.
    // The checker's count is registered, so the first edge is always taken
    // before the count is looked at.
    task automatic wait_for_replies();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_replies != 0) @(posedge clk);
    endtask

    // One register write: a setup cycle, then an access cycle that completes
    // at the edge where pready is seen high.
    task automatic write_register(input logic [1:0] reg_idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    // Reprograms the plane geometry. The block must be idle first, so all
    // responses are collected and any clear pass is allowed to run out.
    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned c);
        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(CFG_IDX_WIDTH, w);
        write_register(CFG_IDX_HEIGHT, h);
        write_register(CFG_IDX_COUNT, c);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        geo_w = w;
        geo_h = h;
        geo_c = c;
    endtask

    // Response side. Ready follows a random pattern, stays high while gaps
    // are off, and drops for a long counted stretch when a hold is asked for,
    // so that the block backs up and stalls its request channel.
    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (holds_served != holds_asked) begin
                holds_served++;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp_bus.ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= GAP_PERCENT);
        end
    end

    // Watchdog: any accepted word on either channel or on the register port
    // counts as progress. A stuck block ends the run here.
    always @(posedge clk) begin
        if (!rst_n || (req_bus.valid && req_bus.ready) ||
            (rsp_bus.valid && rsp_bus.ready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_req_type               kind;
        logic [CHAN_W-1:0]       chan;
        logic [POS_W-1:0]        pos;
        logic [DEF_DELTA_WIDTH-1:0] grad;
        int unsigned             area;
        int unsigned             counted;

        // Every input of the block is driven from time zero.
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        req_bus.valid    <= 1'b0;
        req_bus.req_type <= REQ_NONE;
        req_bus.channel  <= '0;
        req_bus.position <= '0;
        req_bus.delta    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. With four by four planes and two channels the store
        // entries are channel * 16 + position. The first entry is driven to
        // both saturation rails, and every kind of range error is hit at least once.
        set_geometry(4, 4, 2);
        // A read carries a delta that must be ignored.
        send_word(REQ_READ,  6'd0,  12'd0,    32'h1234_5678);
        send_word(REQ_ACCUM, 6'd0,  12'd0,    32'h7FFF_FFFF);
        // Adding to the largest value holds it there.
        send_word(REQ_ACCUM, 6'd0,  12'd0,    32'h0000_0001);
        send_word(REQ_ACCUM, 6'd0,  12'd0,    32'h8000_0000);
        // A sum below the smallest value is held at the smallest.
        send_word(REQ_ACCUM, 6'd0,  12'd0,    32'h8000_0000);
        send_word(REQ_ACCUM, 6'd0,  12'd0,    32'hFFFF_FFFF);
        send_word(REQ_READ,  6'd0,  12'd0,    32'h0000_0000);
        // Last entry of the last channel.
        send_word(REQ_ACCUM, 6'd1,  12'd15,   32'h0001_8000);
        send_word(REQ_READ,  6'd1,  12'd15,   32'hFFFF_FFFF);
        // Channel out of range, both fields at their maximum, and a position
        // equal to the plane area.
        send_word(REQ_READ,  6'd2,  12'd0,    32'h0000_0000);
        send_word(REQ_ACCUM, 6'd63, 12'd4095, 32'h7FFF_FFFF);
        send_word(REQ_ACCUM, 6'd0,  12'd16,   32'h0000_0001);
        // The unused request code is swallowed without a response.
        send_word(REQ_NONE,  6'd63, 12'd4095, 32'hFFFF_FFFF);
        send_word(REQ_CLEAR, 6'd0,  12'd0,    32'h0000_0000);
        send_word(REQ_READ,  6'd0,  12'd0,    32'h0000_0000);
        send_word(REQ_READ,  6'd1,  12'd15,   32'h0000_0000);

        // A zero width or height leaves no position in range.
        set_geometry(0, 4, 2);
        send_word(REQ_ACCUM, 6'd0,  12'd0,    32'h0000_0001);
        send_word(REQ_READ,  6'd0,  12'd0,    32'h0000_0000);
        set_geometry(4, 0, 2);
        send_word(REQ_READ,  6'd0,  12'd0,    32'h0000_0000);

        // Large planes: positions past entry 1023 pass the area check but
        // fall beyond the end of the store.
        set_geometry(64, 64, 1);
        send_word(REQ_ACCUM, 6'd0,  12'd1023, 32'h0000_0005);
        send_word(REQ_ACCUM, 6'd0,  12'd1024, 32'h0000_0005);
        send_word(REQ_READ,  6'd0,  12'd4095, 32'h0000_0000);
        send_word(REQ_READ,  6'd0,  12'd1023, 32'h0000_0000);

        // Random part. The first phases use extreme geometries, the rest
        // mostly small ones. Most words are in-range accumulates and reads,
        // a good share of them on a few hot entries so that sums reach the
        // rails; the remainder is out-of-range noise, unused codes and the
        // occasional clear.
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_geometry(1, 1, 64);
                1: set_geometry(64, 16, 1);
                2: set_geometry(64, 64, 64);
                3: set_geometry(1, 64, 16);
                default: begin
                    if ($urandom_range(99) < 80) begin
                        set_geometry($urandom_range(8, 1), $urandom_range(8, 1),
                                     $urandom_range(8, 1));
                    end else begin
                        set_geometry($urandom_range(64, 1), $urandom_range(64, 1),
                                     $urandom_range(64, 1));
                    end
                end
            endcase

            // Two phases run with no idling on either side, and one of them starts
            // with a long receiver hold-off while the sender keeps offering.
            no_gaps = (phase == CALM_PHASE) || (phase == HOLD_PHASE);
            if (phase == HOLD_PHASE) holds_asked++;

            area    = geo_w * geo_h;
            counted = 0;
            while (counted < WORDS_PER_PHASE) begin
                case ($urandom_range(99)) inside
                    [0:0]:   kind = REQ_CLEAR;
                    [1:3]:   kind = REQ_NONE;
                    [4:57]:  kind = REQ_ACCUM;
                    default: kind = REQ_READ;
                endcase

                if (area == 0 || $urandom_range(99) < NOISE_PERCENT) begin
                    chan = CHAN_W'($urandom);
                    pos  = POS_W'($urandom);
                end else if ($urandom_range(99) < HOT_PERCENT) begin
                    chan = '0;
                    pos  = POS_W'($urandom_range((area < 4) ? area - 1 : 3));
                end else begin
                    chan = CHAN_W'($urandom_range(geo_c - 1));
                    pos  = POS_W'($urandom_range(area - 1));
                end

                case ($urandom_range(3))
                    0: grad = $urandom;
                    1: begin
                        case ($urandom_range(3))
                            0:       grad = 32'h7FFF_FFFF;
                            1:       grad = 32'h8000_0000;
                            2:       grad = 32'h4000_0000;
                            default: grad = 32'hC000_0000;
                        endcase
                    end
                    default: begin
                        grad = $urandom_range(32'h000F_FFFF);
                        if ($urandom_range(1) == 1) grad = -grad;
                    end
                endcase

                send_word(kind, chan, pos, grad);
                if (kind != REQ_NONE) counted++;
            end
            no_gaps = 1'b0;
        end

        // Collect every outstanding response, wait a further drain margin in which
        // any stray word would show, then report.
        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_replies == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- maxpool_gradient_scatter_accumulate_top.f -----
hw/rtl/mgsa_pkg.sv
hw/rtl/mgsa_req_if.sv
hw/rtl/mgsa_rsp_if.sv
hw/rtl/mgsa_cfg.sv
hw/rtl/mgsa_ctrl.sv
hw/rtl/mgsa_dp.sv
hw/rtl/maxpool_gradient_scatter_accumulate_top.sv
tb/sv/mgsa_gradient_checker.sv
tb/sv/tb_maxpool_gradient_scatter_accumulate_top.sv
